/* src/s38_pkg.sv */
package s38_pkg;

    localparam int MAX_INTERVALS = 63;

    localparam int N_W     = 6;
    localparam int LIM_W   = 24;
    localparam int POS_W   = 25;
    localparam int REM_W   = 25;
    localparam int STEP_W  = 5;
    localparam int RCP_W   = 17;
    localparam int END_W   = 18;
    localparam int SUM_W   = 24;
    localparam int MULT_W  = 26;
    localparam int PROD_W  = 50;
    localparam int RND_W   = 32;

    localparam logic [N_W-1:0]    INTERVAL_RESET = N_W'(6);
    localparam logic [POS_W-1:0]  ONE_Q16        = POS_W'(65536);
    localparam logic [REM_W-1:0]  RCP_REM_BASE   = REM_W'(32768);
    localparam logic [STEP_W-1:0] STEP_DIV_STEPS = STEP_W'(24);
    localparam logic [STEP_W-1:0] RCP_DIV_STEPS  = STEP_W'(17);
    localparam logic [STEP_W-1:0] MUL_STEPS      = STEP_W'(24);
    localparam logic [PROD_W:0]   RND_HALF       = (PROD_W+1)'(262144);
    localparam logic [RND_W-1:0]  OUT_MAX_MAG    = RND_W'(16777215);
    localparam logic [RND_W-1:0]  OUT_MIN_MAG    = RND_W'(16777216);
    localparam logic [POS_W-1:0]  OUT_MAX        = 25'h0FFFFFF;
    localparam logic [POS_W-1:0]  OUT_MIN        = 25'h1000000;

    typedef struct packed {
        logic                start;
        logic [REM_W-1:0]    rem_init;
        logic [LIM_W-1:0]    dividend;
        logic [REM_W-1:0]    divisor;
        logic [STEP_W-1:0]   steps;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [LIM_W-1:0]    quotient;
    } t_div_rsp;

endpackage

/* src/s38_div.sv */
module s38_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  s38_pkg::t_div_req i_req,
    output s38_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [s38_pkg::STEP_W-1:0]     r_count;
    logic [s38_pkg::REM_W-1:0]      r_rem;
    logic [s38_pkg::LIM_W-1:0]      r_dvd;
    logic [s38_pkg::REM_W-1:0]      r_dvs;
    logic [s38_pkg::LIM_W-1:0]      r_quot;

    logic [s38_pkg::REM_W:0]        trial;
    logic                           ge;
    logic [s38_pkg::REM_W-1:0]      n_rem;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        trial = {r_rem, r_dvd[s38_pkg::LIM_W-1]};
        ge    = trial >= {1'b0, r_dvs};
        n_rem = ge ? s38_pkg::REM_W'(trial - {1'b0, r_dvs})
                   : trial[s38_pkg::REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_count == s38_pkg::STEP_W'(1));
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_count <= i_req.steps;
                r_rem   <= i_req.rem_init;
                r_dvd   <= i_req.dividend;
                r_dvs   <= i_req.divisor;
                r_quot  <= '0;
            end else if (r_busy) begin
                r_rem   <= n_rem;
                r_dvd   <= {r_dvd[s38_pkg::LIM_W-2:0], 1'b0};
                r_quot  <= {r_quot[s38_pkg::LIM_W-2:0], ge};
                r_count <= r_count - 1'b1;
                if (r_count == s38_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quot;

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_count != '0)
        else $error("divider busy with zero step count");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.start && i_req.steps != '0) |=> r_busy)
        else $error("divider did not start");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");

endmodule

/* src/simpson_three_eighths_integrator.sv */
// each sample point takes one reciprocal pass of the shared radix-2 divider,
// the step takes one pass and the 3h/8 scaling a shift-add multiply;
// the next input waits for the result
// reset: synchronous active low, clears control state, interval count resets to 6
module simpson_three_eighths_integrator (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [5:0]               i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [23:0]              i_lower_limit,
    input  logic [23:0]              i_upper_limit,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [24:0]       o_integral
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_H_START,
        S_H_WAIT,
        S_P_START,
        S_P_WAIT,
        S_SUM,
        S_TRIPLE,
        S_MUL,
        S_ROUND,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [s38_pkg::N_W-1:0]         r_interval_count;
    logic [s38_pkg::N_W-1:0]         r_n;
    logic [s38_pkg::N_W-1:0]         r_point;
    logic [1:0]                      r_mod3;
    logic                            r_neg;
    logic [s38_pkg::LIM_W-1:0]       r_mag;
    logic [s38_pkg::LIM_W-1:0]       r_lo;
    logic [s38_pkg::POS_W-1:0]       r_step;
    logic [s38_pkg::POS_W-1:0]       r_pos;
    logic [s38_pkg::END_W-1:0]       r_end_sum;
    logic [s38_pkg::SUM_W-1:0]       r_dbl_sum;
    logic [s38_pkg::SUM_W-1:0]       r_tri_sum;
    logic [s38_pkg::MULT_W-1:0]      r_mult;
    logic [s38_pkg::PROD_W-1:0]      r_prod;
    logic [s38_pkg::STEP_W-1:0]      r_mul_count;
    logic [s38_pkg::POS_W-1:0]       r_result;
    logic                            r_out_valid;
    logic [s38_pkg::POS_W-1:0]       r_integral;

    s38_pkg::t_div_req               div_req;
    s38_pkg::t_div_rsp               div_rsp;

    logic                            in_xfer;
    logic [s38_pkg::POS_W-1:0]       diff;
    logic [s38_pkg::N_W-1:0]         n_clamped;
    logic [s38_pkg::POS_W-1:0]       denom;
    logic [s38_pkg::RCP_W-1:0]       recip;
    logic [s38_pkg::MULT_W-1:0]      weighted;
    logic [s38_pkg::PROD_W:0]        rounded;
    logic [s38_pkg::RND_W-1:0]       res_mag;
    logic [s38_pkg::POS_W-1:0]       res_val;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        diff = {1'b0, i_upper_limit} - {1'b0, i_lower_limit};
        if (r_interval_count == '0) begin
            n_clamped = s38_pkg::N_W'(1);
        end else if (r_interval_count > s38_pkg::N_W'(s38_pkg::MAX_INTERVALS)) begin
            n_clamped = s38_pkg::N_W'(s38_pkg::MAX_INTERVALS);
        end else begin
            n_clamped = r_interval_count;
        end
    end

    // divider requests: step magnitude / n, then (2^32 + d/2) / d per point
    always_comb begin
        denom = s38_pkg::POS_W'(r_pos[s38_pkg::LIM_W-1:0]) + s38_pkg::ONE_Q16;
        div_req = '0;
        case (r_state)
            S_H_START: begin
                div_req.start    = 1'b1;
                div_req.rem_init = '0;
                div_req.dividend = r_mag;
                div_req.divisor  = s38_pkg::REM_W'(r_n);
                div_req.steps    = s38_pkg::STEP_DIV_STEPS;
            end
            S_P_START: begin
                div_req.start    = 1'b1;
                div_req.rem_init = s38_pkg::RCP_REM_BASE
                                 + s38_pkg::REM_W'(denom[24:18]);
                div_req.dividend = {denom[17:1], 7'b0};
                div_req.divisor  = denom;
                div_req.steps    = s38_pkg::RCP_DIV_STEPS;
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    s38_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        recip    = div_rsp.quotient[s38_pkg::RCP_W-1:0];
        weighted = s38_pkg::MULT_W'(r_end_sum)
                 + s38_pkg::MULT_W'({r_dbl_sum, 1'b0})
                 + s38_pkg::MULT_W'({r_tri_sum, 1'b0})
                 + s38_pkg::MULT_W'(r_tri_sum);
        rounded  = {1'b0, r_prod} + s38_pkg::RND_HALF;
        res_mag  = rounded[s38_pkg::PROD_W:19];
        if (r_neg) begin
            res_val = (res_mag > s38_pkg::OUT_MIN_MAG) ? s38_pkg::OUT_MIN
                    : s38_pkg::POS_W'(-res_mag[s38_pkg::POS_W-1:0]);
        end else begin
            res_val = (res_mag > s38_pkg::OUT_MAX_MAG) ? s38_pkg::OUT_MAX
                    : res_mag[s38_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_interval_count <= s38_pkg::INTERVAL_RESET;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_interval_count <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_lo    <= i_lower_limit;
                        r_n     <= n_clamped;
                        r_neg   <= diff[s38_pkg::POS_W-1];
                        r_mag   <= diff[s38_pkg::POS_W-1]
                                 ? s38_pkg::LIM_W'(-diff) : diff[s38_pkg::LIM_W-1:0];
                        r_state <= S_H_START;
                    end
                end
                S_H_START: begin
                    r_state <= S_H_WAIT;
                end
                S_H_WAIT: begin
                    if (div_rsp.done) begin
                        r_step    <= r_neg ? s38_pkg::POS_W'(-{1'b0, div_rsp.quotient})
                                           : {1'b0, div_rsp.quotient};
                        r_mag     <= div_rsp.quotient;
                        r_pos     <= {1'b0, r_lo};
                        r_point   <= '0;
                        r_mod3    <= 2'd0;
                        r_end_sum <= '0;
                        r_dbl_sum <= '0;
                        r_tri_sum <= '0;
                        r_state   <= S_P_START;
                    end
                end
                S_P_START: begin
                    r_state <= S_P_WAIT;
                end
                S_P_WAIT: begin
                    if (div_rsp.done) begin
                        if (r_point == '0 || r_point == r_n) begin
                            r_end_sum <= r_end_sum + s38_pkg::END_W'(recip);
                        end else if (r_mod3 == 2'd0) begin
                            r_dbl_sum <= r_dbl_sum + s38_pkg::SUM_W'(recip);
                        end else begin
                            r_tri_sum <= r_tri_sum + s38_pkg::SUM_W'(recip);
                        end
                        if (r_point == r_n) begin
                            r_state <= S_SUM;
                        end else begin
                            r_point <= r_point + 1'b1;
                            r_mod3  <= (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 2'd1;
                            r_pos   <= r_pos + r_step;
                            r_state <= S_P_START;
                        end
                    end
                end
                S_SUM: begin
                    r_mult  <= weighted;
                    r_state <= S_TRIPLE;
                end
                S_TRIPLE: begin
                    r_mult      <= r_mult + s38_pkg::MULT_W'({r_mult, 1'b0});
                    r_prod      <= '0;
                    r_mul_count <= s38_pkg::MUL_STEPS;
                    r_state     <= S_MUL;
                end
                S_MUL: begin
                    r_prod      <= {r_prod[s38_pkg::PROD_W-2:0], 1'b0}
                                 + (r_mag[s38_pkg::LIM_W-1]
                                    ? s38_pkg::PROD_W'(r_mult) : '0);
                    r_mag       <= {r_mag[s38_pkg::LIM_W-2:0], 1'b0};
                    r_mul_count <= r_mul_count - 1'b1;
                    if (r_mul_count == s38_pkg::STEP_W'(1)) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_result <= res_val;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_integral  <= r_result;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_integral  = r_integral;

    a_point_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P_WAIT) |-> r_point <= r_n)
        else $error("sample index past interval count");

    a_mod3_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P_WAIT) |-> r_mod3 != 2'd3)
        else $error("weight phase out of range");

    a_xfer_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state == S_H_START)
        else $error("input transfer did not start step division");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside done state");

endmodule
